// ----- hdl/rgbpt_pkg.sv -----
package rgbpt_pkg;

  localparam int EntryW = 16;
  localparam int ColorW = 24;
  localparam int ChanW  = 5;
  localparam int CfgW   = 24;

  localparam logic [ColorW-1:0] ColorWhite    = 24'hFFFFFF;
  localparam logic [7:0]        DarknessReset = 8'd180;
  localparam logic [7:0]        FullStrength  = 8'd255;
  localparam logic [EntryW-1:0] FullEntry     = 16'h0001;

  typedef enum logic [2:0] {
    REG_TINT_MODE    = 3'd0,
    REG_FOG_ENABLE   = 3'd1,
    REG_FOG_COLOR    = 3'd2,
    REG_FOG_DARKNESS = 3'd3,
    REG_TINT_COLOR   = 3'd4,
    REG_TINT_ALPHA   = 3'd5,
    REG_REMAP_FLOOR  = 3'd6
  } reg_index_t;

  // Programmed register values
  typedef struct packed {
    logic              tint_mode;
    logic              fog_enable;
    logic [ColorW-1:0] fog_color;
    logic [7:0]        fog_darkness;
    logic [ColorW-1:0] tint_color;
    logic [7:0]        tint_alpha;
    logic [ColorW-1:0] remap_floor;
  } tint_regs_t;

  // Effective lerp target (5-bit channels) and strength
  typedef struct packed {
    logic [ChanW-1:0] target_r;
    logic [ChanW-1:0] target_g;
    logic [ChanW-1:0] target_b;
    logic [7:0]       strength;
  } lerp_params_t;

  typedef struct packed {
    logic [EntryW-1:0] entry;
    logic              active;
  } qitem_t;

endpackage

// ----- hdl/rgbpt_cfg.sv -----
module rgbpt_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [rgbpt_pkg::CfgW-1:0] cfg_data,
  output rgbpt_pkg::tint_regs_t      regs,
  output rgbpt_pkg::lerp_params_t    params
);
  import rgbpt_pkg::*;

  // (f * (255 - a) + t * a) / 255, folded to one multiply: f*255 + (t - f)*a
  function automatic logic [7:0] mix255(input logic [7:0] f, input logic [7:0] t,
                                        input logic [7:0] a);
    logic signed [17:0] x;
    logic [16:0]        y;
    x = $signed({2'b00, f, 8'h00}) - $signed({10'b0, f})
        + ($signed({1'b0, t}) - $signed({1'b0, f})) * $signed({1'b0, a});
    // exact divide by 255 for a 16-bit dividend
    y = 17'(x[15:0]) + 17'(x[15:8]) + 17'd1;
    return y[15:8];
  endfunction

  logic         fog_on;
  logic         tint_on;
  logic [7:0]   fr;
  logic [7:0]   fg;
  logic [7:0]   fb;
  logic [7:0]   fa;
  lerp_params_t params_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tint_mode    <= 1'b0;
      regs.fog_enable   <= 1'b0;
      regs.fog_color    <= '0;
      regs.fog_darkness <= DarknessReset;
      regs.tint_color   <= ColorWhite;
      regs.tint_alpha   <= '0;
      regs.remap_floor  <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_TINT_MODE:    regs.tint_mode    <= cfg_data[0];
        REG_FOG_ENABLE:   regs.fog_enable   <= cfg_data[0];
        REG_FOG_COLOR:    regs.fog_color    <= cfg_data[ColorW-1:0];
        REG_FOG_DARKNESS: regs.fog_darkness <= cfg_data[7:0];
        REG_TINT_COLOR:   regs.tint_color   <= cfg_data[ColorW-1:0];
        REG_TINT_ALPHA:   regs.tint_alpha   <= cfg_data[7:0];
        REG_REMAP_FLOOR:  regs.remap_floor  <= cfg_data[ColorW-1:0];
        default: ;
      endcase
    end
  end

  assign fog_on  = regs.fog_enable;
  assign tint_on = (regs.tint_alpha != 8'd0);

  always_comb begin
    if (fog_on && !tint_on) begin
      fr = regs.fog_color[23:16];
      fg = regs.fog_color[15:8];
      fb = regs.fog_color[7:0];
      fa = regs.fog_darkness;
    end else if (!fog_on) begin
      fr = regs.tint_color[23:16];
      fg = regs.tint_color[15:8];
      fb = regs.tint_color[7:0];
      fa = regs.tint_alpha;
    end else begin
      fr = mix255(regs.fog_color[23:16], regs.tint_color[23:16], regs.tint_alpha);
      fg = mix255(regs.fog_color[15:8], regs.tint_color[15:8], regs.tint_alpha);
      fb = mix255(regs.fog_color[7:0], regs.tint_color[7:0], regs.tint_alpha);
      fa = mix255(regs.fog_darkness, regs.tint_alpha, regs.tint_alpha);
    end
    params_next.target_r = fr[7:3];
    params_next.target_g = fg[7:3];
    params_next.target_b = fb[7:3];
    params_next.strength = fa;
  end

  // Refresh every cycle; params is registered again from regs, so it follows each register write
  always_ff @(posedge clk) begin
    params <= params_next;
  end

endmodule

// ----- hdl/rgbpt_front.sv -----
module rgbpt_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rgbpt_pkg::EntryW-1:0] s_tdata,
  input  rgbpt_pkg::tint_regs_t        regs,
  input  logic                         q_full,
  output logic                         q_push,
  output rgbpt_pkg::qitem_t            q_item
);
  import rgbpt_pkg::*;

  logic remap_ident;
  logic active;

  assign remap_ident = (regs.tint_color == ColorWhite) && (regs.remap_floor == '0);

  // Tag each entry: pass through or tint
  always_comb begin
    if (regs.tint_mode) begin
      active = regs.fog_enable || !remap_ident;
    end else begin
      active = regs.fog_enable || (regs.tint_alpha != 8'd0);
    end
  end

  assign s_tready      = !q_full;
  assign q_push        = s_tvalid && !q_full;
  assign q_item.entry  = s_tdata;
  assign q_item.active = active;

endmodule

// ----- hdl/rgbpt_queue.sv -----
module rgbpt_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rgbpt_pkg::qitem_t push_item,
  output logic              full,
  input  logic              pop,
  output rgbpt_pkg::qitem_t head,
  output logic              empty
);
  import rgbpt_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qitem_t          slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ----- hdl/rgbpt_back.sv -----
module rgbpt_back (
  input  logic                         clk,
  input  logic                         rst,
  input  rgbpt_pkg::tint_regs_t        regs,
  input  rgbpt_pkg::lerp_params_t      params,
  input  rgbpt_pkg::qitem_t            head,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [rgbpt_pkg::EntryW-1:0] m_tdata,
  output logic                         m_tuser
);
  import rgbpt_pkg::*;

  // c + (t - c) * a / 256, truncating toward zero
  function automatic logic [ChanW-1:0] lerp_chan(input logic [ChanW-1:0] c,
                                                 input logic [ChanW-1:0] t,
                                                 input logic [7:0] a);
    logic signed [6:0]  d;
    logic signed [14:0] p;
    logic signed [14:0] q;
    d = $signed({2'b00, t}) - $signed({2'b00, c});
    p = d * $signed({1'b0, a});
    q = (p + (p[14] ? 15'sd255 : 15'sd0)) >>> 8;
    return c + q[ChanW-1:0];
  endfunction

  function automatic logic [ChanW-1:0] remap_chan(input logic [ChanW-1:0] c,
                                                  input logic [7:0] scale,
                                                  input logic [7:0] flo);
    logic [12:0] prod;
    logic [5:0]  v;
    prod = 13'(c) * 13'(scale);
    v    = 6'(flo[7:3]) + 6'(prod[12:8]);
    return v[5] ? 5'h1F : v[ChanW-1:0];
  endfunction

  logic              load;
  logic [ChanW-1:0]  r;
  logic [ChanW-1:0]  g;
  logic [ChanW-1:0]  b;
  logic [EntryW-1:0] result;

  assign load  = !q_empty && (!m_tvalid || m_tready);
  assign q_pop = load;

  always_comb begin
    if (regs.tint_mode) begin
      r = remap_chan(head.entry[15:11], regs.tint_color[23:16], regs.remap_floor[23:16]);
      g = remap_chan(head.entry[10:6], regs.tint_color[15:8], regs.remap_floor[15:8]);
      b = remap_chan(head.entry[5:1], regs.tint_color[7:0], regs.remap_floor[7:0]);
    end else begin
      r = lerp_chan(head.entry[15:11], params.target_r, params.strength);
      g = lerp_chan(head.entry[10:6], params.target_g, params.strength);
      b = lerp_chan(head.entry[5:1], params.target_b, params.strength);
    end
    if (!head.active) begin
      result = head.entry;
    end else if (!regs.tint_mode && params.strength == FullStrength) begin
      result = FullEntry;
    end else begin
      result = {r, g, b, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= result;
      m_tuser <= head.active;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst) load |=> m_tvalid)
    else $error("loaded result not presented");
  a_alpha_set: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tdata[0])
    else $error("tinted entry without alpha bit");
  a_no_load_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !load)
    else $error("output overwritten while stalled");

endmodule

// ----- hdl/rgba5551_palette_tint_unit.sv -----
// An input entry passes through the queue, then the output register, to appear on m_tvalid.
// Throughput: one entry per cycle; the 2-entry queue and output register keep both sides
// independent, so a stalled output only stops input once the queue fills.
// Reset (rst, synchronous): empties the queue, drops m_tvalid and loads the register defaults;
// the effective lerp target and strength are re-registered from them and follow any write.
module rgba5551_palette_tint_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] entry
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] tinted_entry
  output logic        m_tuser,   // [0] tint_active
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import rgbpt_pkg::*;

  tint_regs_t   regs;
  lerp_params_t params;
  qitem_t       q_item;
  qitem_t       q_head;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;

  rgbpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs),
    .params    (params)
  );

  rgbpt_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .regs     (regs),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  rgbpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  rgbpt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .params   (params),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
